// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/btlpt_pkg.sv -----
// ----------------------------------------------------------------------------
// btlpt_pkg
// Shared constants, types and helpers of the beat to loop phase tracker.
// ----------------------------------------------------------------------------
package btlpt_pkg;

    // default fixed-point format of the beat position
    localparam int FRAC_BITS_DEF = 16;
    localparam int INT_BITS_DEF  = 24;

    // configuration register widths and reset values
    localparam int BEATS_W   = 11;
    localparam int SAMPLES_W = 24;
    localparam logic [BEATS_W-1:0]   BEATS_RST   = 11'd16;
    localparam logic [SAMPLES_W-1:0] SAMPLES_RST = 24'd96000;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BEATS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_SAMPLES = 1'b1;

    // result beat layout
    localparam int OUT_TDATA_W     = 32;
    localparam int OUT_MOVING_BIT  = SAMPLES_W;
    localparam int OUT_REWOUND_BIT = SAMPLES_W + 1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FLAGS,
        S_DIFF,
        S_ABS,
        S_MOD,
        S_MFIX,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // larger of two elaboration-time values
    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- hw/rtl/beat_to_loop_phase_tracker.sv -----
// ----------------------------------------------------------------------------
// beat_to_loop_phase_tracker
// Turns a host beat position into a sample index inside the loop, with
// moving and rewind flags, using one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// One input beat yields one result beat; the beat position is Q24.16 by
// default. An extra negation step is taken when the beat lies below the
// loop origin, and the input side is ready again in the cycle the result
// appears; with either loop length register at zero the modulo, multiply
// and divide are skipped and the phase index is zero. The single adder
// runs the bit-serial floor modulo over the INT_BITS + 1 integer bits, the
// shift-add multiply over 11 + FRAC_BITS bits and the 24-step restoring
// divide, one step per cycle. The result sits in an output register, so the
// next input is taken while it waits. Loop lengths may be written only while
// no item is in flight.
module beat_to_loop_phase_tracker #(
    parameter int FRAC_BITS = btlpt_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = btlpt_pkg::INT_BITS_DEF,
    localparam int IN_TDATA_W = ((INT_BITS + FRAC_BITS + 3 + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input beat
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // beat_position, any_loop_audio, speed_known, speed_nonzero, zero fill
    input  logic [IN_TDATA_W-1:0]                 s_tdata,
    // result beat
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // phase_index, moving, rewound, zero fill
    output logic [btlpt_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [btlpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [btlpt_pkg::SAMPLES_W-1:0]       cfg_data
);
    import btlpt_pkg::*;

    localparam int BEAT_W    = INT_BITS + FRAC_BITS;
    localparam int D_W       = INT_BITS + 1;
    localparam int R_W       = BEATS_W + FRAC_BITS;
    localparam int PR_W      = R_W + SAMPLES_W;
    localparam int DV_W      = max_int(D_W, SAMPLES_W);
    localparam int ALU_W     = max_int(BEAT_W + 2, PR_W + 1);
    localparam int STEPS_MAX = max_int(DV_W, R_W);
    localparam int CNT_W     = $clog2(STEPS_MAX);
    localparam int IDX_W     = $clog2(DV_W);
    localparam int PAD_W     = OUT_TDATA_W - SAMPLES_W - 2;
    localparam logic [ALU_W-1:0] HALF_BEAT     = ALU_W'(1) << (FRAC_BITS - 1);
    localparam logic [ALU_W-1:0] NEG_HALF_BEAT = ALU_W'(0) - HALF_BEAT;

    // control state
    state_t                 state_reg;
    state_t                 state_next;
    logic [BEATS_W-1:0]     beats_reg;
    logic [SAMPLES_W-1:0]   samples_reg;
    logic [BEAT_W-1:0]      last_reg;
    logic                   last_valid_reg;
    logic [BEAT_W-1:0]      origin_reg;
    logic                   origin_valid_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   m_tvalid_reg;

    // datapath
    logic [BEAT_W-1:0]      beat_reg;
    logic                   audio_reg;
    logic                   known_reg;
    logic                   nonzero_reg;
    logic                   moving_reg;
    logic                   rewound_reg;
    logic                   neg_reg;
    logic                   zero_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [DV_W-1:0]        dvd_reg;
    logic [BEATS_W-1:0]     rem_reg;
    logic [R_W-1:0]         mul_reg;
    logic [PR_W-1:0]        acc_reg;
    logic [SAMPLES_W-1:0]   quo_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // shared adder and helpers
    logic [ALU_W-1:0]       alu_a;
    logic [ALU_W-1:0]       alu_b;
    logic                   alu_sub;
    logic [ALU_W-1:0]       alu_sum;
    logic                   take;
    logic                   cnt_zero;
    logic                   out_free;
    logic                   zero_len;
    logic                   in_bit;
    logic                   moving_c;
    logic                   rewound_c;
    logic [BEATS_W-1:0]     mod_val;
    logic [SAMPLES_W-1:0]   phase_c;

    assign alu_sum  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign take     = !alu_sum[ALU_W-1];
    assign cnt_zero = (cnt_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign zero_len = (beats_reg == '0) || (samples_reg == '0);
    assign in_bit   = dvd_reg[cnt_reg[IDX_W-1:0]];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // transport flags from beat minus last beat
    always_comb
    begin
        if (last_valid_reg)
            moving_c = take && (alu_sum != '0);
        else
            moving_c = known_reg && nonzero_reg;
        if (known_reg && !nonzero_reg)
            moving_c = 1'b0;
        rewound_c = last_valid_reg && ($signed(alu_sum) < $signed(NEG_HALF_BEAT));
    end

    // floor-mod fix-up for a negative offset
    assign mod_val = (neg_reg && (rem_reg != '0)) ? alu_sum[BEATS_W-1:0] : rem_reg;

    // clamp of the quotient to the last sample, zero when a loop length is zero
    assign phase_c = zero_reg ? '0 :
                     ((quo_reg >= samples_reg) ? (samples_reg - SAMPLES_W'(1)) : quo_reg);

    // sequencer: next state and adder operands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = S_FLAGS;
            end
            S_FLAGS:
            begin
                alu_a      = ALU_W'($signed(beat_reg));
                alu_b      = ALU_W'($signed(last_reg));
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                alu_a = ALU_W'($signed(beat_reg));
                alu_b = origin_valid_reg ? ALU_W'($signed(origin_reg)) : '0;
                if (zero_len)
                    state_next = S_DONE;
                else if (alu_sum[ALU_W-1])
                    state_next = S_ABS;
                else
                    state_next = S_MOD;
            end
            S_ABS:
            begin
                alu_b      = ALU_W'($signed(dvd_reg[D_W-1:0]));
                state_next = S_MOD;
            end
            S_MOD:
            begin
                alu_a = ALU_W'({rem_reg, in_bit});
                alu_b = ALU_W'(beats_reg);
                if (cnt_zero)
                    state_next = S_MFIX;
            end
            S_MFIX:
            begin
                alu_a      = ALU_W'(beats_reg);
                alu_b      = ALU_W'(rem_reg);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                alu_sub = 1'b0;
                alu_a   = ALU_W'({acc_reg[PR_W-2:0], 1'b0});
                alu_b   = mul_reg[R_W-1] ? ALU_W'(samples_reg) : '0;
                if (cnt_zero)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                alu_a = ALU_W'({rem_reg, in_bit});
                alu_b = ALU_W'(beats_reg);
                if (cnt_zero)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers: loop lengths, tracking state, step counter, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_reg        <= BEATS_RST;
            samples_reg      <= SAMPLES_RST;
            last_reg         <= '0;
            last_valid_reg   <= 1'b0;
            origin_reg       <= '0;
            origin_valid_reg <= 1'b0;
            cnt_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOOP_BEATS:   beats_reg   <= cfg_data[BEATS_W-1:0];
                    CFG_LOOP_SAMPLES: samples_reg <= cfg_data;
                    default:          ;
                endcase
            end

            if (state_reg == S_FLAGS)
            begin
                last_reg       <= beat_reg;
                last_valid_reg <= 1'b1;
                if (rewound_c)
                begin
                    origin_reg       <= audio_reg ? beat_reg : '0;
                    origin_valid_reg <= audio_reg;
                end
            end

            case (state_reg)
                S_DIFF:  cnt_reg <= CNT_W'(D_W - 1);
                S_MFIX:  cnt_reg <= CNT_W'(R_W - 1);
                S_MUL:   cnt_reg <= cnt_zero ? CNT_W'(SAMPLES_W - 1) : cnt_reg - CNT_W'(1);
                S_MOD,
                S_DIV:   cnt_reg <= cnt_reg - CNT_W'(1);
                default: ;
            endcase

            if ((state_reg == S_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    beat_reg    <= s_tdata[BEAT_W-1:0];
                    audio_reg   <= s_tdata[BEAT_W];
                    known_reg   <= s_tdata[BEAT_W+1];
                    nonzero_reg <= s_tdata[BEAT_W+2];
                end
            end
            S_FLAGS:
            begin
                moving_reg  <= moving_c;
                rewound_reg <= rewound_c;
            end
            // split the offset into integer beats and fraction
            S_DIFF:
            begin
                neg_reg  <= alu_sum[ALU_W-1];
                zero_reg <= zero_len;
                frac_reg <= alu_sum[FRAC_BITS-1:0];
                dvd_reg  <= DV_W'(alu_sum[BEAT_W:FRAC_BITS]);
                rem_reg  <= '0;
            end
            S_ABS:
            begin
                dvd_reg <= DV_W'(alu_sum[D_W-1:0]);
            end
            // restoring step of the beat modulo
            S_MOD:
            begin
                rem_reg <= take ? alu_sum[BEATS_W-1:0] : {rem_reg[BEATS_W-2:0], in_bit};
            end
            S_MFIX:
            begin
                mul_reg <= {mod_val, frac_reg};
                acc_reg <= '0;
            end
            // shift-add step of phase times loop samples
            S_MUL:
            begin
                acc_reg <= alu_sum[PR_W-1:0];
                mul_reg <= {mul_reg[R_W-2:0], 1'b0};
                if (cnt_zero)
                begin
                    rem_reg <= alu_sum[PR_W-1:FRAC_BITS+SAMPLES_W];
                    dvd_reg <= DV_W'(alu_sum[FRAC_BITS+SAMPLES_W-1:FRAC_BITS]);
                end
            end
            // restoring step of the divide by loop beats
            S_DIV:
            begin
                rem_reg <= take ? alu_sum[BEATS_W-1:0] : {rem_reg[BEATS_W-2:0], in_bit};
                quo_reg <= {quo_reg[SAMPLES_W-2:0], take};
            end
            S_DONE:
            begin
                if (out_free)
                    m_tdata_reg <= {{PAD_W{1'b0}}, rewound_reg, moving_reg, phase_c};
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/btlpt_checker.sv -----
// ----------------------------------------------------------------------------
// btlpt_checker
// Port-level checks of the beat to loop phase tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btlpt_checker #(
    parameter int FRAC_BITS = btlpt_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = btlpt_pkg::INT_BITS_DEF,
    localparam int IN_TDATA_W = ((INT_BITS + FRAC_BITS + 3 + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // beat_position, any_loop_audio, speed_known, speed_nonzero, zero fill
    input  logic [IN_TDATA_W-1:0]             s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // phase_index, moving, rewound, zero fill
    input  logic [btlpt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                              cfg_we,
    input  logic [btlpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btlpt_pkg::SAMPLES_W-1:0]   cfg_data
);
    import btlpt_pkg::*;

    logic [SAMPLES_W-1:0] samples_reg;
    logic                 in_beat;
    logic [SAMPLES_W-1:0] phase;

    assign in_beat = s_tvalid && s_tready && (s_tdata == s_tdata);
    assign phase   = m_tdata[SAMPLES_W-1:0];

    // shadow of the loop length in samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            samples_reg <= SAMPLES_RST;
        else if (cfg_we && (cfg_index == CFG_LOOP_SAMPLES))
            samples_reg <= cfg_data;
    end

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // the block works on one item at a time
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_beat, !s_tready)

    // phase index stays inside the loop
    `ASSERT_SAME(a_phase_range, clk, rst_n, m_tvalid, (phase == '0) || (phase < samples_reg))

    // a rewind never counts as forward motion
    `ASSERT_SAME(a_rewind_not_moving, clk, rst_n, m_tvalid && m_tdata[OUT_REWOUND_BIT],
                 !m_tdata[OUT_MOVING_BIT])

endmodule

bind beat_to_loop_phase_tracker btlpt_checker #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
) u_btlpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
